FILE: src/pngunf_pkg.sv
// shared types, codes and the paeth predictor for the png row unfilter
`default_nettype none
package pngunf_pkg;

   localparam int unsigned DEF_MAX_WIDTH  = 1024;
   localparam int unsigned BPP_MAX        = 4;
   localparam int unsigned CFG_WIDTH_W    = 11;
   localparam int unsigned CFG_HEIGHT_W   = 16;
   localparam int unsigned CSR_DATA_W     = 16;
   localparam int unsigned CSR_INDEX_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [1:0] MODE_GRAY = 2'd0;
   localparam logic [1:0] MODE_RGB  = 2'd1;
   localparam logic [1:0] MODE_RGBA = 2'd2;

   localparam logic [7:0] FLT_NONE  = 8'd0;
   localparam logic [7:0] FLT_SUB   = 8'd1;
   localparam logic [7:0] FLT_UP    = 8'd2;
   localparam logic [7:0] FLT_AVG   = 8'd3;
   localparam logic [7:0] FLT_PAETH = 8'd4;

   // per-beat control handed from the position tracker to the rebuild stage
   typedef struct packed {
      logic [7:0] data;
      logic       is_filter;
      logic       first_row;
      logic [1:0] chan;
      logic       complete;
      logic       row_end;
      logic       image_end;
      logic       gray;
   } beat_ctrl_type;

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [10:0] sa;
      logic signed [10:0] sb;
      logic signed [10:0] sc;
      logic signed [10:0] pa;
      logic signed [10:0] pb;
      logic signed [10:0] pc;
      logic [7:0]         pick;
      sa = $signed({3'b000, a});
      sb = $signed({3'b000, b});
      sc = $signed({3'b000, c});
      pa = sb - sc;
      pb = sa - sc;
      pc = sa + sb - sc - sc;
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage
`default_nettype wire

FILE: src/png_row_unfilter_pixel_pack.sv
// top level: png scanline unfilter with rgb pixel packing
//
//   channel  direction  handshake              beat
//   req      in         req_valid / req_stall  one stream byte, image start flag
//   rsp      out        rsp_valid / rsp_stall  one rgb pixel with row/image end marks
//   csr      in         csr_valid / csr_ready  register index and write data
//
// one byte per cycle while req_stall is low; a completing byte's pixel passes through the stage register,
// paired with the registered read of the previous-row store ahead of the filter math, then the output register.
// reset is synchronous and clears the counters and neighbor bytes; the row store is not
// cleared and the first row of every image reads zero above.
// rsp_stall with a full output register and a completing pixel waiting holds req_stall.
`default_nettype none
module png_row_unfilter_pixel_pack
   import pngunf_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_stream_byte,
   input  wire logic                   req_image_start,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_red,
   output logic [7:0]                  rsp_green,
   output logic [7:0]                  rsp_blue,
   output logic                        rsp_row_end,
   output logic                        rsp_image_end,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned STORE_DEPTH = MAX_WIDTH * BPP_MAX;
   localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
   localparam int unsigned STRIDE_W    = $clog2(STORE_DEPTH + 1);
   localparam int unsigned MW_W        = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CMP_W       = (MW_W > CFG_WIDTH_W) ? MW_W : CFG_WIDTH_W;

   logic [1:0]              mode_ff;
   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;

   logic [1:0]              bpp_last;
   logic                    gray;
   logic [CMP_W-1:0]        w_eff;
   logic [STRIDE_W-1:0]     w_s, stride;
   logic [CFG_HEIGHT_W-1:0] height_last;

   logic                    accept, go;
   beat_ctrl_type           s0_ctrl;
   logic [ADDR_W-1:0]       s0_slot;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [7:0]              wr_data, rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RGB;
         width_ff  <= CFG_WIDTH_W'(1);
         height_ff <= CFG_HEIGHT_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLOR_MODE:   mode_ff   <= csr_data[1:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // unused mode code behaves as rgb
      gray     = (mode_ff == MODE_GRAY);
      bpp_last = gray ? 2'd0 : ((mode_ff == MODE_RGBA) ? 2'd3 : 2'd2);
      if (width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(width_ff);
      end
      w_s = STRIDE_W'(w_eff);
      if (gray) begin
         stride = w_s;
      end else if (mode_ff == MODE_RGBA) begin
         stride = w_s << 2;
      end else begin
         stride = (w_s << 1) + w_s;
      end
      height_last = (height_ff == '0) ? '0 : height_ff - CFG_HEIGHT_W'(1);
   end

   assign req_stall = !go;
   assign accept    = req_valid && go;

   pngunf_track #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_stream_byte),
      .image_start (req_image_start),
      .bpp_last    (bpp_last),
      .gray        (gray),
      .stride      (stride),
      .height_last (height_last),
      .ctrl        (s0_ctrl),
      .slot        (s0_slot)
   );

   pngunf_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (s0_slot),
      .rd_data (rd_data)
   );

   pngunf_recon #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_recon (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .s0_ctrl       (s0_ctrl),
      .s0_slot       (s0_slot),
      .rd_data       (rd_data),
      .go            (go),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_row_end   (rsp_row_end),
      .rsp_image_end (rsp_image_end)
   );

endmodule
`default_nettype wire

FILE: src/pngunf_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module pngunf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/pngunf_track.sv
// position tracker: filter byte, column, channel, row and end-of-row/image marks
`default_nettype none
module pngunf_track
   import pngunf_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int unsigned STORE_DEPTH = MAX_WIDTH * BPP_MAX,
   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH),
   localparam int unsigned STRIDE_W = $clog2(STORE_DEPTH + 1),
   localparam int unsigned COL_W = $clog2(STORE_DEPTH) + 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              stream_byte,
   input  wire logic                    image_start,
   input  wire logic [1:0]              bpp_last,
   input  wire logic                    gray,
   input  wire logic [STRIDE_W-1:0]     stride,
   input  wire logic [CFG_HEIGHT_W-1:0] height_last,
   output beat_ctrl_type                ctrl,
   output logic [ADDR_W-1:0]            slot
);

   logic [COL_W-1:0]        col_ff, col_in, col_cur, x;
   logic [CFG_HEIGHT_W-1:0] row_ff, row_in, row_cur;
   logic                    first_ff, first_in, first_cur;
   logic [1:0]              chan_ff, chan_in;
   logic                    is_filter, complete, rend, last_row;

   always_comb begin
      col_cur   = image_start ? '0 : col_ff;
      row_cur   = image_start ? '0 : row_ff;
      first_cur = image_start | first_ff;
      x         = col_cur - COL_W'(1);
      // store index wraps when a mid-row config change runs past the end
      if (x >= COL_W'(STORE_DEPTH)) begin
         slot = ADDR_W'(x - COL_W'(STORE_DEPTH));
      end else begin
         slot = ADDR_W'(x);
      end
      is_filter = (col_cur == '0);
      complete  = !is_filter && (chan_ff >= bpp_last);
      rend      = complete && (col_cur >= COL_W'(stride));
      last_row  = (row_cur >= height_last);

      ctrl.data      = stream_byte;
      ctrl.is_filter = is_filter;
      ctrl.first_row = first_cur;
      ctrl.chan      = chan_ff;
      ctrl.complete  = complete;
      ctrl.row_end   = rend;
      ctrl.image_end = rend && last_row;
      ctrl.gray      = gray;

      col_in   = col_ff;
      row_in   = row_ff;
      first_in = first_ff;
      chan_in  = chan_ff;
      if (accept) begin
         row_in   = row_cur;
         first_in = first_cur;
         if (is_filter) begin
            col_in  = COL_W'(1);
            chan_in = 2'd0;
         end else begin
            chan_in = complete ? 2'd0 : chan_ff + 2'd1;
            col_in  = rend ? '0 : col_cur + COL_W'(1);
            if (rend) begin
               row_in   = last_row ? '0 : row_cur + CFG_HEIGHT_W'(1);
               first_in = last_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         first_ff <= 1'b1;
         chan_ff  <= 2'd0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         first_ff <= first_in;
         chan_ff  <= chan_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/pngunf_recon.sv
// rebuild stage: filter arithmetic on the store read, neighbor regs, pixel pack, output reg
`default_nettype none
module pngunf_recon
   import pngunf_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int unsigned STORE_DEPTH = MAX_WIDTH * BPP_MAX,
   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire beat_ctrl_type     s0_ctrl,
   input  wire logic [ADDR_W-1:0] s0_slot,
   input  wire logic [7:0]        rd_data,
   output logic                   go,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [7:0]             wr_data,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_red,
   output logic [7:0]             rsp_green,
   output logic [7:0]             rsp_blue,
   output logic                   rsp_row_end,
   output logic                   rsp_image_end
);

   logic                s1_valid_ff, s1_valid_in;
   beat_ctrl_type       s1_ctrl_ff;
   logic [ADDR_W-1:0]   s1_slot_ff;
   logic                fwd_ff, fwd_in;
   logic [7:0]          fwd_data_ff;

   logic [7:0]          row_filter_ff, row_filter_in;
   logic [7:0]          left_ff [BPP_MAX];
   logic [7:0]          left_in [BPP_MAX];
   logic [7:0]          upleft_ff [BPP_MAX];
   logic [7:0]          upleft_in [BPP_MAX];
   logic [23:0]         gather_ff, gather_in;

   logic                out_valid_ff, out_valid_in;
   logic [7:0]          red_ff, green_ff, blue_ff;
   logic                row_end_ff, image_end_ff;

   logic [7:0]          a, b, ul, recon;
   logic [8:0]          avg_sum;
   logic                emit, step;

   always_comb begin
      a       = left_ff[s1_ctrl_ff.chan];
      b       = s1_ctrl_ff.first_row ? 8'd0 : (fwd_ff ? fwd_data_ff : rd_data);
      ul      = s1_ctrl_ff.first_row ? 8'd0 : upleft_ff[s1_ctrl_ff.chan];
      avg_sum = {1'b0, a} + {1'b0, b};
      case (row_filter_ff)
         FLT_SUB:   recon = s1_ctrl_ff.data + a;
         FLT_UP:    recon = s1_ctrl_ff.data + b;
         FLT_AVG:   recon = s1_ctrl_ff.data + avg_sum[8:1];
         FLT_PAETH: recon = s1_ctrl_ff.data + paeth_pick(a, b, ul);
         default:   recon = s1_ctrl_ff.data;
      endcase

      emit = s1_valid_ff && s1_ctrl_ff.complete;
      go   = !emit || !out_valid_ff || !rsp_stall;
      step = s1_valid_ff && go;

      wr_en   = step && !s1_ctrl_ff.is_filter;
      wr_addr = s1_slot_ff;
      wr_data = recon;

      row_filter_in = row_filter_ff;
      left_in       = left_ff;
      upleft_in     = upleft_ff;
      gather_in     = gather_ff;
      if (step) begin
         if (s1_ctrl_ff.is_filter) begin
            row_filter_in = s1_ctrl_ff.data;
            for (int i = 0; i < BPP_MAX; i++) begin
               left_in[i]   = 8'd0;
               upleft_in[i] = 8'd0;
            end
            gather_in = 24'd0;
         end else begin
            left_in[s1_ctrl_ff.chan]   = recon;
            upleft_in[s1_ctrl_ff.chan] = b;
            // alpha never lands in the pixel word
            case (s1_ctrl_ff.chan)
               2'd0:    gather_in[23:16] = recon;
               2'd1:    gather_in[15:8]  = recon;
               2'd2:    gather_in[7:0]   = recon;
               default: gather_in        = gather_ff;
            endcase
         end
      end

      out_valid_in = (out_valid_ff && rsp_stall) || (step && emit);

      s1_valid_in = accept || (s1_valid_ff && !go);
      // same-entry read and write in one edge: take the write data
      fwd_in = fwd_ff;
      if (accept) begin
         fwd_in = wr_en && (wr_addr == s0_slot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         row_filter_ff <= FLT_NONE;
         gather_ff     <= 24'd0;
         for (int i = 0; i < BPP_MAX; i++) begin
            left_ff[i]   <= 8'd0;
            upleft_ff[i] <= 8'd0;
         end
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_ff        <= fwd_in;
         out_valid_ff  <= out_valid_in;
         row_filter_ff <= row_filter_in;
         gather_ff     <= gather_in;
         left_ff       <= left_in;
         upleft_ff     <= upleft_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff  <= s0_ctrl;
         s1_slot_ff  <= s0_slot;
         fwd_data_ff <= wr_data;
      end
      if (step && emit) begin
         if (s1_ctrl_ff.gray) begin
            red_ff   <= recon;
            green_ff <= recon;
            blue_ff  <= recon;
         end else begin
            red_ff   <= gather_in[23:16];
            green_ff <= gather_in[15:8];
            blue_ff  <= gather_in[7:0];
         end
         row_end_ff   <= s1_ctrl_ff.row_end;
         image_end_ff <= s1_ctrl_ff.image_end;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_image_end = image_end_ff;

endmodule
`default_nettype wire

FILE: src/pngunf_checker.sv
// port-level checks for the png row unfilter, bound to the top level
`default_nettype none
module pngunf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_red,
   input wire logic [7:0] rsp_green,
   input wire logic [7:0] rsp_blue,
   input wire logic       rsp_row_end,
   input wire logic       rsp_image_end
);

   // a stalled pixel beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_row_end) && $stable(rsp_image_end))
      else $error("stalled rsp beat changed");

   // the last pixel of an image is also the last of its row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_row_end)
      else $error("image end without row end");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a new pixel follows the taken byte that completed it, through the stage and output registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("rsp beat without a matching req beat");

   // the input only stalls behind a full, stalled output register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a stalled rsp beat");

endmodule

bind png_row_unfilter_pixel_pack pngunf_checker u_checker (.*);
`default_nettype wire

FILE: tb/png_row_unfilter_pixel_pack_tb.sv
`timescale 1ns / 1ps
// testbench for the png row unfilter: rebuilds every pixel in software and checks each rsp beat
import pngunf_pkg::*;

typedef struct packed {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       row_end;
   logic       image_end;
} rgb_pixel_type;

class pixel_scoreboard;
   logic [1:0]    color_mode;
   logic [10:0]   image_width;
   logic [15:0]   image_height;
   logic [7:0]    upper_row [DEF_MAX_WIDTH * BPP_MAX];
   logic [7:0]    left_px [BPP_MAX];
   logic [7:0]    upper_left_px [BPP_MAX];
   logic [7:0]    row_filter;
   int unsigned   byte_col;
   int unsigned   row_count;
   bit            top_row;
   logic [23:0]   gathered;
   int unsigned   chan;
   rgb_pixel_type expected_pixels [$];
   int unsigned   mismatches;

   function new();
      color_mode = MODE_RGB;
      image_width = 11'd1;
      image_height = 16'd1;
      row_filter = FLT_NONE;
      byte_col = 0;
      row_count = 0;
      top_row = 1'b1;
      mismatches = 0;
      clear_neighbors();
   endfunction

   function void clear_neighbors();
      foreach (left_px[i]) begin
         left_px[i] = 8'd0;
         upper_left_px[i] = 8'd0;
      end
      chan = 0;
      gathered = 24'd0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] reg_index, logic [CSR_DATA_W-1:0] value);
      case (reg_index)
         CSR_COLOR_MODE:   color_mode = value[1:0];
         CSR_IMAGE_WIDTH:  image_width = value[CFG_WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: image_height = value[CFG_HEIGHT_W-1:0];
         default: ;
      endcase
   endfunction

   function int unsigned bytes_per_pixel();
      if (color_mode == MODE_GRAY) return 1;
      if (color_mode == MODE_RGBA) return 4;
      return 3;
   endfunction

   function int unsigned row_bytes();
      int unsigned w;
      w = (image_width == 0) ? 1 : image_width;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      return w * bytes_per_pixel();
   endfunction

   function int unsigned rows_per_image();
      return (image_height == 0) ? 1 : image_height;
   endfunction

   function bit at_image_boundary();
      return top_row && byte_col == 0;
   endfunction

   function int unsigned pending();
      return expected_pixels.size();
   endfunction

   function logic [7:0] paeth_predict(int a, int b, int c);
      int p;
      int da;
      int db;
      int dc;
      p = a + b - c;
      da = (p > a) ? p - a : a - p;
      db = (p > b) ? p - b : b - p;
      dc = (p > c) ? p - c : c - p;
      if (da <= db && da <= dc) return a[7:0];
      if (db <= dc) return b[7:0];
      return c[7:0];
   endfunction

   // rebuilds one stream byte and queues the pixel it completes, if any
   function void accept_byte(logic [7:0] data, logic start);
      int unsigned   bpp;
      int unsigned   stride;
      int unsigned   x;
      int unsigned   c;
      int unsigned   slot;
      logic [7:0]    a;
      logic [7:0]    b;
      logic [7:0]    ul;
      logic [7:0]    recon;
      rgb_pixel_type px;
      bpp = bytes_per_pixel();
      stride = row_bytes();
      if (start) begin
         byte_col = 0;
         row_count = 0;
         top_row = 1'b1;
      end
      if (byte_col == 0) begin
         row_filter = data;
         byte_col = 1;
         clear_neighbors();
         return;
      end
      x = byte_col - 1;
      c = chan & 3;
      slot = x % (DEF_MAX_WIDTH * BPP_MAX);
      a = left_px[c];
      b = top_row ? 8'd0 : upper_row[slot];
      ul = top_row ? 8'd0 : upper_left_px[c];
      case (row_filter)
         FLT_SUB:   recon = data + a;
         FLT_UP:    recon = data + b;
         FLT_AVG:   recon = data + 8'(({1'b0, a} + {1'b0, b}) >> 1);
         FLT_PAETH: recon = data + paeth_predict(a, b, ul);
         default:   recon = data;
      endcase
      upper_row[slot] = recon;
      left_px[c] = recon;
      upper_left_px[c] = b;
      if (c < 3) gathered[23 - 8*c -: 8] = recon;
      byte_col++;
      if (c + 1 < bpp) begin
         chan = c + 1;
         return;
      end
      if (bpp == 1) begin
         px.red = recon;
         px.green = recon;
         px.blue = recon;
      end else begin
         px.red = gathered[23:16];
         px.green = gathered[15:8];
         px.blue = gathered[7:0];
      end
      px.row_end = (x + 1 >= stride);
      px.image_end = 1'b0;
      chan = 0;
      if (px.row_end) begin
         byte_col = 0;
         if (row_count >= rows_per_image() - 1) begin
            px.image_end = 1'b1;
            row_count = 0;
            top_row = 1'b1;
         end else begin
            row_count = (row_count + 1) & 16'hFFFF;
            top_row = 1'b0;
         end
      end
      expected_pixels.push_back(px);
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   function void check_pixel(rgb_pixel_type got);
      rgb_pixel_type want;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         $display("%0t: pixel expected none actual %h", $time, got);
         return;
      end
      want = expected_pixels.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("row_end", want.row_end, got.row_end);
      compare_field("image_end", want.image_end, got.image_end);
   endfunction
endclass

module png_row_unfilter_pixel_pack_tb;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_ITEMS  = 560;
   localparam int unsigned WIDE_BYTES    = 200;
   localparam int unsigned HOLD_FROM     = 700;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned CALM_FROM     = 1500;
   localparam int unsigned CALM_CYCLES   = 600;
   localparam logic [1:0]  MODE_UNUSED   = 2'd3;
   localparam logic [7:0]  FLT_UNKNOWN   = 8'hFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_stream_byte = 8'd0;
   logic                   req_image_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_red;
   logic [7:0]             rsp_green;
   logic [7:0]             rsp_blue;
   logic                   rsp_row_end;
   logic                   rsp_image_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   pixel_scoreboard sb;
   int unsigned     sent_count = 0;
   int unsigned     rsp_cycle = 0;

   png_row_unfilter_pixel_pack u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_row_end     (rsp_row_end),
      .rsp_image_end   (rsp_image_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // pixel sink: checks each beat, then picks the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_pixel({rsp_red, rsp_green, rsp_blue, rsp_row_end, rsp_image_end});
      end
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_cycle >= HOLD_FROM && rsp_cycle < HOLD_FROM + HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
      end else if (rsp_cycle >= CALM_FROM && rsp_cycle < CALM_FROM + CALM_CYCLES) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 33);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic start);
      bit steady;
      steady = (sent_count >= 300 && sent_count < 450);
      if (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= data;
      req_image_start <= start;
      do @(posedge clock); while (req_stall);
      sb.accept_byte(data, start);
      sent_count++;
   endtask

   // registers change only once the block has drained
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(reg_index, value);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [10:0] width,
                            input logic [15:0] height);
      write_csr(CSR_COLOR_MODE, CSR_DATA_W'(mode));
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(width));
      write_csr(CSR_IMAGE_HEIGHT, height);
   endtask

   // one image of random rows, possibly cut short; an open image forces a start flag
   task automatic play_image(input int unsigned max_rows, input bit allow_cut);
      int unsigned stride;
      int unsigned rows;
      int unsigned total;
      int unsigned cut_at;
      int unsigned n;
      logic [7:0]  filt;
      logic        start;
      stride = sb.row_bytes();
      rows = sb.rows_per_image();
      if (rows > max_rows) rows = max_rows;
      total = rows * (stride + 1);
      cut_at = total;
      if (allow_cut && total > 1 && $urandom_range(0, 99) < 15) begin
         cut_at = $urandom_range(1, total - 1);
      end
      start = sb.at_image_boundary() ? 1'($urandom_range(0, 1)) : 1'b1;
      n = 0;
      for (int unsigned r = 0; r < rows && n < cut_at; r++) begin
         filt = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(FLT_NONE, FLT_PAETH))
                                             : 8'($urandom_range(0, 255));
         send_byte(filt, start);
         start = 1'b0;
         n++;
         for (int unsigned k = 0; k < stride && n < cut_at; k++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            n++;
         end
      end
   endtask

   initial begin
      logic [7:0] first_row_px [6];
      logic [7:0] second_row_px [4];
      first_row_px = '{8'h10, 8'hF0, 8'h33, 8'hC8, 8'h01, 8'hFE};
      second_row_px = '{8'h80, 8'h7F, 8'h00, 8'hFF};
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: rgb, one pixel per row, one row per image
      send_byte(FLT_NONE, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hAA, 1'b0);
      // next image follows the image end without a start flag
      send_byte(FLT_SUB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);

      // unused mode, zero width and zero height, unknown filter
      configure(MODE_UNUSED, 11'd0, 16'd0);
      send_byte(FLT_UNKNOWN, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);

      configure(MODE_RGB, 11'd2, 16'd3);
      send_byte(FLT_PAETH, 1'b1);
      foreach (first_row_px[i]) send_byte(first_row_px[i], 1'b0);
      send_byte(FLT_AVG, 1'b0);
      foreach (second_row_px[i]) send_byte(second_row_px[i], 1'b0);
      // gray, one pixel, one row mid-row: the half-built pixel closes row and image
      configure(MODE_GRAY, 11'd1, 16'd1);
      send_byte(8'h5A, 1'b0);

      while (sent_count < RANDOM_ITEMS) begin
         configure(2'($urandom_range(0, 3)),
                   ($urandom_range(0, 99) < 80) ? 11'($urandom_range(1, 6))
                                                : 11'($urandom_range(0, 24)),
                   16'($urandom_range(0, 3)));
         repeat ($urandom_range(1, 3)) play_image(8, 1'b1);
      end

      // width past the row store saturates: a long gray row must not end early
      configure(MODE_GRAY, 11'h7FF, 16'd1);
      send_byte(FLT_PAETH, 1'b1);
      for (int k = 0; k < WIDE_BYTES; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      // tallest image, left open
      configure(MODE_RGBA, 11'd2, 16'hFFFF);
      play_image(5, 1'b0);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

FILE: filelist.f
src/pngunf_pkg.sv
src/pngunf_ram.sv
src/pngunf_track.sv
src/pngunf_recon.sv
src/png_row_unfilter_pixel_pack.sv
src/pngunf_checker.sv
tb/png_row_unfilter_pixel_pack_tb.sv
